// File: sv/qrs_pkg.sv
`timescale 1ns / 1ps

package qrs_pkg;

  // Stream field and bus widths
  localparam int FIELD_W    = 32;
  localparam int IN_DATA_W  = 3 * FIELD_W;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 2;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register map (index = paddr / 4)
  localparam logic [APB_ADDR_W-3:0] REG_TOL_IDX = '0;
  localparam logic [APB_DATA_W-1:0] TOL_RESET   = 32'd429497;

  // Root count codes
  localparam logic [1:0] ROOTS_NONE = 2'd0;
  localparam logic [1:0] ROOTS_ONE  = 2'd1;
  localparam logic [1:0] ROOTS_TWO  = 2'd2;

  // Positions of the result fields on the output stream
  localparam int OUT_COUNT_LSB  = 0;
  localparam int OUT_FIRST_LSB  = 2;
  localparam int OUT_SECOND_LSB = OUT_FIRST_LSB + FIELD_W;
  localparam int OUT_USED_W     = OUT_SECOND_LSB + FIELD_W;
  localparam int USER_LZ_BIT    = 0;
  localparam int USER_OVF_BIT   = 1;

  // One finished result item
  typedef struct packed {
    logic [FIELD_W-1:0] root_second;
    logic [FIELD_W-1:0] root_first;
    logic [1:0]         root_count;
    logic               root_overflow;
    logic               leading_zero;
  } result_t;

endpackage

// File: sv/qrs_sqrt_cell.sv
`timescale 1ns / 1ps

// One bit of a restoring square root: brings in two radicand bits, decides one root bit.
module qrs_sqrt_cell #(
  parameter int SW     = 34,
  parameter int SIDE_W = 70
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [2*SW-1:0]   rad_i,
  input  logic [SW:0]       rem_i,
  input  logic [SW-1:0]     root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [2*SW-1:0]   rad_o,
  output logic [SW:0]       rem_o,
  output logic [SW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q;
  logic [2*SW-1:0]   rad_q, rad_d;
  logic [SW:0]       rem_q, rem_d;
  logic [SW-1:0]     root_q, root_d;
  logic [SIDE_W-1:0] side_q;
  logic [SW+2:0]     rem2, trial, diff;
  logic              ge;

  // Trial subtract of 4r+1 from the shifted remainder
  always_comb begin
    rem2   = {rem_i, rad_i[2*SW-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    diff   = rem2 - trial;
    ge     = (rem2 >= trial);
    rem_d  = ge ? diff[SW:0] : rem2[SW:0];
    root_d = {root_i[SW-2:0], ge};
    rad_d  = {rad_i[2*SW-3:0], 2'b00};
  end

  // Advance valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

// File: sv/qrs_div_cell.sv
`timescale 1ns / 1ps

// One quotient bit of a restoring divide, two lanes sharing one divisor.
// The dividend shifts out at the top while quotient bits shift in at the bottom.
module qrs_div_cell #(
  parameter int NB     = 50,
  parameter int DVW    = 33,
  parameter int SIDE_W = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [NB-1:0]     nq_i  [2],
  input  logic [DVW-1:0]    rem_i [2],
  input  logic [DVW-1:0]    dv_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [NB-1:0]     nq_o  [2],
  output logic [DVW-1:0]    rem_o [2],
  output logic [DVW-1:0]    dv_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q;
  logic [NB-1:0]     nq_q  [2];
  logic [NB-1:0]     nq_d  [2];
  logic [DVW-1:0]    rem_q [2];
  logic [DVW-1:0]    rem_d [2];
  logic [DVW-1:0]    dv_q;
  logic [SIDE_W-1:0] side_q;
  logic [DVW:0]      rem2  [2];
  logic [DVW:0]      diff  [2];
  logic [1:0]        ge;

  // Compare and subtract per lane
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem2[l]  = {rem_i[l], nq_i[l][NB-1]};
      diff[l]  = rem2[l] - {1'b0, dv_i};
      ge[l]    = (rem2[l] >= {1'b0, dv_i});
      rem_d[l] = ge[l] ? diff[l][DVW-1:0] : rem2[l][DVW-1:0];
      nq_d[l]  = {nq_i[l][NB-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nq_q   <= nq_d;
      rem_q  <= rem_d;
      dv_q   <= dv_i;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign nq_o   = nq_q;
  assign rem_o  = rem_q;
  assign dv_o   = dv_q;
  assign side_o = side_q;

endmodule

// File: sv/quadratic_root_solver.sv
// Throughput: one item per cycle while the skid stage is empty, set by the chain of square
// root cells (one root bit each) followed by the chain of divide cells (one quotient bit each,
// both roots side by side). An output register plus a one-entry skid stage decouple the
// output from the chain. Reset (rst_ni low, asynchronous) clears all valid bits and loads
// the tolerance register with its default; s_axis_tready is high straight out of reset.
`timescale 1ns / 1ps

module quadratic_root_solver #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // coef_square [31:0], coef_linear [63:32], coef_constant [95:64]
  input  logic [qrs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // root_count [1:0], root_first [33:2], root_second [65:34], zero [71:66]
  output logic [qrs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // leading_zero [0], root_overflow [1]
  output logic [qrs_pkg::OUT_USER_W-1:0]    m_axis_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qrs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [qrs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [qrs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  import qrs_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int DW   = 2 * W + 2;       // discriminant magnitude
  localparam int SW   = W + 2;           // square root bits
  localparam int RW   = 2 * SW;          // radicand bits
  localparam int NSW  = W + 3;           // signed numerator
  localparam int NMW  = W + 2;           // numerator magnitude
  localparam int NB   = NMW + F;         // dividend and quotient bits
  localparam int DVW  = W + 1;           // divisor 2|a|
  localparam int SQS  = 2 * W + 6;       // side data through the root chain
  localparam int DVS  = 5;               // side data through the divide chain
  localparam logic [NB-1:0] Q_HALF   = NB'(1) << (W - 1);
  localparam logic [W-1:0]  SAT_MIN  = W'(1) << (W - 1);
  localparam logic [W-1:0]  SAT_MAX  = ~SAT_MIN;

  // ---------------------------------------------------------------- config port
  logic [APB_DATA_W-1:0] tol_q;
  logic                  wr_tol;

  assign pready = 1'b1;
  assign wr_tol = psel & penable & pwrite & (paddr[APB_ADDR_W-1:2] == REG_TOL_IDX);
  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_TOL_IDX) ? tol_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (wr_tol) begin
      tol_q <= pwdata;
    end
  end

  // ---------------------------------------------------------------- chain enable
  logic en;
  logic skid_vld_q;

  assign en            = ~skid_vld_q;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------- stage 1: capture
  logic         s1_vld_q;
  logic [W-1:0] s1_a_q, s1_b_q, s1_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_a_q <= s_axis_tdata[W-1:0];
      s1_b_q <= s_axis_tdata[FIELD_W +: W];
      s1_c_q <= s_axis_tdata[2*FIELD_W +: W];
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  logic [W-1:0]   a_mag, b_mag, c_mag;
  logic [2*W-1:0] bb, pac;

  assign a_mag = s1_a_q[W-1] ? (~s1_a_q + 1'b1) : s1_a_q;
  assign b_mag = s1_b_q[W-1] ? (~s1_b_q + 1'b1) : s1_b_q;
  assign c_mag = s1_c_q[W-1] ? (~s1_c_q + 1'b1) : s1_c_q;
  assign bb    = b_mag * b_mag;
  assign pac   = a_mag * c_mag;

  logic           s2_vld_q;
  logic [2*W-1:0] s2_bb_q, s2_p_q;
  logic           s2_pneg_q, s2_asgn_q, s2_lz_q;
  logic [W-1:0]   s2_amag_q, s2_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_bb_q   <= bb;
      s2_p_q    <= pac;
      s2_pneg_q <= s1_a_q[W-1] ^ s1_c_q[W-1];
      s2_asgn_q <= s1_a_q[W-1];
      s2_lz_q   <= (s1_a_q == '0);
      s2_amag_q <= a_mag;
      s2_b_q    <= s1_b_q;
    end
  end

  // ---------------------------------------------------------------- stage 3: discriminant
  logic [DW-1:0]  bbx, p4, dmag;
  logic           dneg, near;
  logic [1:0]     mode;
  logic [W+1:0]   bx, negb;

  assign bbx = {2'b00, s2_bb_q};
  assign p4  = {s2_p_q, 2'b00};

  always_comb begin
    if (s2_pneg_q) begin
      dmag = bbx + p4;
      dneg = 1'b0;
    end else if (bbx >= p4) begin
      dmag = bbx - p4;
      dneg = 1'b0;
    end else begin
      dmag = p4 - bbx;
      dneg = 1'b1;
    end
    near = (dmag < DW'(tol_q));
    if (s2_lz_q) begin
      mode = ROOTS_NONE;
    end else if (near) begin
      mode = ROOTS_ONE;
    end else if (dneg) begin
      mode = ROOTS_NONE;
    end else begin
      mode = ROOTS_TWO;
    end
  end

  assign bx   = {{2{s2_b_q[W-1]}}, s2_b_q};
  assign negb = ~bx + 1'b1;

  logic           s3_vld_q;
  logic [DW-1:0]  s3_dmag_q;
  logic [SQS-1:0] s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  // side: negb, |a|, sign of a, mode, leading zero
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_dmag_q <= dmag;
      s3_side_q <= {negb, s2_amag_q, s2_asgn_q, mode, s2_lz_q};
    end
  end

  // ---------------------------------------------------------------- square root chain
  logic           sq_vld  [SW+1];
  logic [RW-1:0]  sq_rad  [SW+1];
  logic [SW:0]    sq_rem  [SW+1];
  logic [SW-1:0]  sq_root [SW+1];
  logic [SQS-1:0] sq_side [SW+1];

  assign sq_vld[0]  = s3_vld_q;
  assign sq_rad[0]  = {2'b00, s3_dmag_q};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = s3_side_q;

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    qrs_sqrt_cell #(
      .SW     (SW),
      .SIDE_W (SQS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sq_vld[k]),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .side_i (sq_side[k]),
      .vld_o  (sq_vld[k+1]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .side_o (sq_side[k+1])
    );
  end

  // ---------------------------------------------------------------- stage 4: numerators
  logic [SQS-1:0] sq_out;
  logic [W+1:0]   r_negb;
  logic [W-1:0]   r_amag;
  logic           r_asgn, r_lz;
  logic [1:0]     r_mode;
  logic [NSW-1:0] nbx, sx, n1, n2;

  assign sq_out = sq_side[SW];
  assign r_negb = sq_out[SQS-1 -: W+2];
  assign r_amag = sq_out[W+3:4];
  assign r_asgn = sq_out[3];
  assign r_mode = sq_out[2:1];
  assign r_lz   = sq_out[0];
  assign nbx    = {r_negb[W+1], r_negb};
  assign sx     = {1'b0, sq_root[SW]};
  assign n1     = (r_mode == ROOTS_ONE) ? nbx : (nbx + sx);
  assign n2     = nbx - sx;

  logic           s4_vld_q;
  logic [NSW-1:0] s4_n1_q, s4_n2_q;
  logic [W-1:0]   s4_amag_q;
  logic           s4_asgn_q, s4_lz_q;
  logic [1:0]     s4_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= sq_vld[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_n1_q   <= n1;
      s4_n2_q   <= n2;
      s4_amag_q <= r_amag;
      s4_asgn_q <= r_asgn;
      s4_mode_q <= r_mode;
      s4_lz_q   <= r_lz;
    end
  end

  // ---------------------------------------------------------------- stage 5: magnitudes
  logic [NSW-1:0] m1, m2;

  assign m1 = s4_n1_q[NSW-1] ? (~s4_n1_q + 1'b1) : s4_n1_q;
  assign m2 = s4_n2_q[NSW-1] ? (~s4_n2_q + 1'b1) : s4_n2_q;

  logic           dv_vld  [NB+1];
  logic [NB-1:0]  dv_nq   [NB+1][2];
  logic [DVW-1:0] dv_rem  [NB+1][2];
  logic [DVW-1:0] dv_dv   [NB+1];
  logic [DVS-1:0] dv_side [NB+1];

  logic           s5_vld_q;
  logic [NB-1:0]  s5_nq_q [2];
  logic [DVW-1:0] s5_dv_q;
  logic [DVS-1:0] s5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  // side: neg2, neg1, mode, leading zero
  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_nq_q[0] <= {m1[NMW-1:0], {F{1'b0}}};
      s5_nq_q[1] <= {m2[NMW-1:0], {F{1'b0}}};
      s5_dv_q    <= {s4_amag_q, 1'b0};
      s5_side_q  <= {s4_n2_q[NSW-1] ^ s4_asgn_q, s4_n1_q[NSW-1] ^ s4_asgn_q,
                     s4_mode_q, s4_lz_q};
    end
  end

  // ---------------------------------------------------------------- divide chain
  assign dv_vld[0]    = s5_vld_q;
  assign dv_nq[0]     = s5_nq_q;
  assign dv_rem[0][0] = '0;
  assign dv_rem[0][1] = '0;
  assign dv_dv[0]     = s5_dv_q;
  assign dv_side[0]   = s5_side_q;

  for (genvar k = 0; k < NB; k++) begin : g_div
    qrs_div_cell #(
      .NB     (NB),
      .DVW    (DVW),
      .SIDE_W (DVS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (dv_vld[k]),
      .nq_i   (dv_nq[k]),
      .rem_i  (dv_rem[k]),
      .dv_i   (dv_dv[k]),
      .side_i (dv_side[k]),
      .vld_o  (dv_vld[k+1]),
      .nq_o   (dv_nq[k+1]),
      .rem_o  (dv_rem[k+1]),
      .dv_o   (dv_dv[k+1]),
      .side_o (dv_side[k+1])
    );
  end

  // ---------------------------------------------------------------- saturate and select
  logic [DVS-1:0]     fin_side;
  logic [1:0]         fin_neg, fin_ovf;
  logic [W-1:0]       fin_val [2];
  logic signed [W-1:0] fin_s1, fin_s2;
  result_t            fin_res;

  assign fin_side = dv_side[NB];
  assign fin_neg  = fin_side[4:3];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      fin_ovf[l] = 1'b0;
      if (fin_neg[l]) begin
        if (dv_nq[NB][l] > Q_HALF) begin
          fin_val[l] = SAT_MIN;
          fin_ovf[l] = 1'b1;
        end else begin
          fin_val[l] = ~dv_nq[NB][l][W-1:0] + 1'b1;
        end
      end else begin
        if (dv_nq[NB][l] > (Q_HALF - 1'b1)) begin
          fin_val[l] = SAT_MAX;
          fin_ovf[l] = 1'b1;
        end else begin
          fin_val[l] = dv_nq[NB][l][W-1:0];
        end
      end
    end
  end

  assign fin_s1 = fin_val[0];
  assign fin_s2 = fin_val[1];

  always_comb begin
    fin_res              = '0;
    fin_res.root_count   = fin_side[2:1];
    fin_res.leading_zero = fin_side[0];
    case (fin_side[2:1])
      ROOTS_ONE: begin
        fin_res.root_first    = FIELD_W'(fin_s1);
        fin_res.root_overflow = fin_ovf[0];
      end
      ROOTS_TWO: begin
        fin_res.root_first    = FIELD_W'(fin_s1);
        fin_res.root_second   = FIELD_W'(fin_s2);
        fin_res.root_overflow = fin_ovf[0] | fin_ovf[1];
      end
      default: begin
        fin_res.root_count = ROOTS_NONE;
      end
    endcase
  end

  // ---------------------------------------------------------------- output register and skid
  logic    out_vld_q;
  result_t out_q, skid_q;
  logic    take, inc;

  assign take = out_vld_q & m_axis_tready;
  assign inc  = en & dv_vld[NB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (take || !out_vld_q) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= inc;
      end
    end else if (inc) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take || !out_vld_q) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (inc) begin
        out_q <= fin_res;
      end
    end else if (inc) begin
      skid_q <= fin_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                          out_q.root_second, out_q.root_first, out_q.root_count};
  assign m_axis_tuser  = {out_q.root_overflow, out_q.leading_zero};

endmodule

// File: sv/qrs_check.sv
`timescale 1ns / 1ps

module qrs_check (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [qrs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [qrs_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  import qrs_pkg::*;

  logic [1:0]         cnt;
  logic [FIELD_W-1:0] r1, r2;
  logic               lz, ovf;

  assign cnt = m_axis_tdata[OUT_COUNT_LSB +: 2];
  assign r1  = m_axis_tdata[OUT_FIRST_LSB +: FIELD_W];
  assign r2  = m_axis_tdata[OUT_SECOND_LSB +: FIELD_W];
  assign lz  = m_axis_tuser[USER_LZ_BIT];
  assign ovf = m_axis_tuser[USER_OVF_BIT];

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  // Count is a legal code
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cnt == ROOTS_NONE || cnt == ROOTS_ONE || cnt == ROOTS_TWO))
    else $error("illegal root count");

  // Zero leading coefficient gives an empty result
  a_lz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && lz |-> cnt == ROOTS_NONE && r1 == '0 && r2 == '0 && !ovf)
    else $error("leading zero item carries roots");

  // No roots means zero fields and no overflow
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && cnt == ROOTS_NONE |-> r1 == '0 && r2 == '0 && !ovf)
    else $error("empty item carries roots");

  // Second root only with two roots
  a_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && cnt != ROOTS_TWO |-> r2 == '0)
    else $error("second root set without two roots");

endmodule

bind quadratic_root_solver qrs_check u_qrs_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
